/* design/vole_cpu_execute_core_macros.svh */
// ----------------------------------------------------------------------------
// Vole execute core assertion macros
// Shared property templates for the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef VOLE_CPU_EXECUTE_CORE_MACROS_SVH
`define VOLE_CPU_EXECUTE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VCE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/vce_pkg.sv */
// ----------------------------------------------------------------------------
// Vole execute core package
// Sizes, request codes and opcodes shared by the core, its channels and checker.
// ----------------------------------------------------------------------------
package vce_pkg;

   localparam int MEMORY_BYTES   = 256;
   localparam int REGISTER_COUNT = 16;
   localparam int ADDR_W         = $clog2(MEMORY_BYTES);
   localparam int REG_IDX_W      = $clog2(REGISTER_COUNT);
   localparam int DATA_W         = 8;

   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_EXECUTE = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   localparam logic [3:0] OP_NONE      = 4'h0;
   localparam logic [3:0] OP_LOAD_MEM  = 4'h1;
   localparam logic [3:0] OP_LOAD_IMM  = 4'h2;
   localparam logic [3:0] OP_STORE     = 4'h3;
   localparam logic [3:0] OP_MOVE      = 4'h4;
   localparam logic [3:0] OP_ADD_INT   = 4'h5;
   localparam logic [3:0] OP_ADD_FLOAT = 4'h6;
   localparam logic [3:0] OP_JUMP_EQ   = 4'hB;
   localparam logic [3:0] OP_HALT      = 4'hC;

   localparam logic [REG_IDX_W-1:0] REG_ZERO     = '0;
   localparam logic [ADDR_W-1:0]    DISPLAY_ADDR = '0;

endpackage

/* design/vce_channels.sv */
// ----------------------------------------------------------------------------
// Vole execute core channels
// Valid/ready channel bundles for requests, responses and the start address.
// ----------------------------------------------------------------------------
interface vce_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [vce_pkg::ADDR_W-1:0]  address;
   logic [vce_pkg::DATA_W-1:0]  data;
   modport source(output valid, req_type, address, data, input ready);
   modport sink(input valid, req_type, address, data, output ready);
endinterface

interface vce_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vce_pkg::ADDR_W-1:0]  program_counter;
   logic                        halted;
   logic                        display_valid;
   logic [vce_pkg::DATA_W-1:0]  display_value;
   logic                        bad_opcode;
   logic [3:0]                  executed_opcode;
   modport source(output valid, program_counter, halted, display_valid, display_value,
                  bad_opcode, executed_opcode, input ready);
   modport sink(input valid, program_counter, halted, display_valid, display_value,
                bad_opcode, executed_opcode, output ready);
endinterface

interface vce_csr_if;
   logic                        valid;
   logic                        ready;
   logic [vce_pkg::ADDR_W-1:0]  data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

/* design/vce_fadd.sv */
// ----------------------------------------------------------------------------
// Vole float adder
// Adds two sign/unbiased-3-bit-exponent/4-bit-mantissa bytes with truncation and saturation.
// ----------------------------------------------------------------------------
module vce_fadd (
   input  logic [vce_pkg::DATA_W-1:0] a_in,
   input  logic [vce_pkg::DATA_W-1:0] b_in,
   output logic [vce_pkg::DATA_W-1:0] sum_out
);

   logic [10:0]        mag_a;
   logic [10:0]        mag_b;
   logic signed [12:0] val_a;
   logic signed [12:0] val_b;
   logic signed [12:0] total;
   logic [11:0]        mag;
   logic [11:0]        shifted;
   logic               found;
   logic [2:0]         exp_sel;
   logic [3:0]         man_sel;

   always_comb begin
      mag_a = {7'd0, a_in[3:0]} << a_in[6:4];
      mag_b = {7'd0, b_in[3:0]} << b_in[6:4];
      val_a = a_in[7] ? -$signed({2'b00, mag_a}) : $signed({2'b00, mag_a});
      val_b = b_in[7] ? -$signed({2'b00, mag_b}) : $signed({2'b00, mag_b});
      total = val_a + val_b;
      mag   = total[12] ? 12'(-total) : total[11:0];
   end

   always_comb begin
      found   = 1'b0;
      exp_sel = 3'd7;
      man_sel = 4'hF;
      shifted = '0;
      for (int i = 0; i < 8; i++) begin
         shifted = mag >> i;
         if (!found && shifted <= 12'd15) begin
            found   = 1'b1;
            exp_sel = 3'(i);
            man_sel = shifted[3:0];
         end
      end
   end

   always_comb begin
      if (mag == '0) begin
         sum_out = '0;
      end else begin
         sum_out = {total[12], exp_sel, man_sel};
      end
   end

endmodule

/* design/vole_cpu_execute_core.sv */
// ----------------------------------------------------------------------------
// Vole execute core
// Eight-bit Vole processor with a 256-byte memory and sixteen registers.
// ----------------------------------------------------------------------------
// Requests arrive on req_bus: a memory byte write, a restart at the start
// address written over csr_bus, or the execution of one instruction. Every request
// returns exactly one response on rsp_bus with the program counter, the halt
// flag, the display byte, the bad opcode flag and the executed opcode.
// An instruction is paced by the single port of the main memory and the single
// read port of the register file: two fetch reads, then one memory read or one
// or two register reads before the write back. The response register holds a
// finished response while the receiver stalls, and a new request is taken in
// the cycle that response leaves. After reset the core clears memory and
// registers and takes no request meanwhile; the start address register
// accepts writes at any time.
// ----------------------------------------------------------------------------
module vole_cpu_execute_core (
   input  logic       clock,
   input  logic       reset,
   vce_req_if.sink    req_bus,
   vce_rsp_if.source  rsp_bus,
   vce_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_MEM_LOAD,
      ST_SINGLE,
      ST_OPERAND_A,
      ST_OPERAND_B
   } state_type;

   localparam int AW = vce_pkg::ADDR_W;
   localparam int DW = vce_pkg::DATA_W;
   localparam int RW = vce_pkg::REG_IDX_W;

   state_type       state_ff, state_in;
   logic [AW-1:0]   clear_cnt_ff, clear_cnt_in;
   logic [AW-1:0]   pc_ff, pc_in;
   logic            halt_ff, halt_in;
   logic [AW-1:0]   start_ff, start_in;
   logic [DW-1:0]   ir_hi_ff, ir_hi_in;
   logic [DW-1:0]   ir_lo_ff, ir_lo_in;
   logic [DW-1:0]   opa_ff, opa_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]   rsp_pc_ff, rsp_pc_in;
   logic            rsp_halt_ff, rsp_halt_in;
   logic            rsp_disp_v_ff, rsp_disp_v_in;
   logic [DW-1:0]   rsp_disp_ff, rsp_disp_in;
   logic            rsp_bad_ff, rsp_bad_in;
   logic [3:0]      rsp_op_ff, rsp_op_in;

   logic [DW-1:0]   mem_array [vce_pkg::MEMORY_BYTES];
   logic [DW-1:0]   mem_rdata_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_addr;
   logic [DW-1:0]   mem_wdata;

   logic [DW-1:0]   rf_array [vce_pkg::REGISTER_COUNT];
   logic [DW-1:0]   rf_rdata_ff;
   logic            rf_we;
   logic [RW-1:0]   rf_waddr;
   logic [RW-1:0]   rf_raddr;
   logic [DW-1:0]   rf_wdata;

   logic            req_ready;
   logic            done;
   logic            done_disp_v;
   logic [DW-1:0]   done_disp;
   logic            done_bad;
   logic [3:0]      done_op;
   logic [3:0]      opcode;
   logic [RW-1:0]   reg_r;
   logic [AW-1:0]   pc_plus2;
   logic [DW-1:0]   fadd_sum;

   vce_fadd u_fadd (
      .a_in    (opa_ff),
      .b_in    (rf_rdata_ff),
      .sum_out (fadd_sum)
   );

   assign opcode   = ir_hi_ff[7:4];
   assign reg_r    = ir_hi_ff[RW-1:0];
   assign pc_plus2 = pc_ff + AW'(2);

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      pc_in        = pc_ff;
      halt_in      = halt_ff;
      start_in     = start_ff;
      ir_hi_in     = ir_hi_ff;
      ir_lo_in     = ir_lo_ff;
      opa_in       = opa_ff;
      mem_we       = 1'b0;
      mem_addr     = pc_ff;
      mem_wdata    = '0;
      rf_we        = 1'b0;
      rf_waddr     = reg_r;
      rf_raddr     = ir_lo_ff[RW-1:0];
      rf_wdata     = '0;
      req_ready    = 1'b0;
      done         = 1'b0;
      done_disp_v  = 1'b0;
      done_disp    = '0;
      done_bad     = 1'b0;
      done_op      = vce_pkg::OP_NONE;

      if (csr_bus.valid) begin
         start_in = csr_bus.data;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_addr     = clear_cnt_ff;
            rf_we        = 1'b1;
            rf_waddr     = clear_cnt_ff[RW-1:0];
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_bus.ready;
            if (req_ready && req_bus.valid) begin
               case (req_bus.req_type)
                  vce_pkg::REQ_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = req_bus.address;
                     mem_wdata = req_bus.data;
                     done      = 1'b1;
                  end
                  vce_pkg::REQ_RESTART: begin
                     pc_in   = start_ff;
                     halt_in = 1'b0;
                     done    = 1'b1;
                  end
                  vce_pkg::REQ_EXECUTE: begin
                     if (halt_ff) begin
                        done = 1'b1;
                     end else begin
                        mem_addr = pc_ff;
                        state_in = ST_FETCH_HI;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH_HI: begin
            ir_hi_in = mem_rdata_ff;
            mem_addr = pc_ff + AW'(1);
            state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            ir_lo_in = mem_rdata_ff;
            case (opcode)
               vce_pkg::OP_LOAD_MEM: begin
                  mem_addr = mem_rdata_ff;
                  state_in = ST_MEM_LOAD;
               end
               vce_pkg::OP_LOAD_IMM: begin
                  rf_we    = 1'b1;
                  rf_wdata = mem_rdata_ff;
                  pc_in    = pc_plus2;
                  done     = 1'b1;
                  done_op  = opcode;
               end
               vce_pkg::OP_STORE, vce_pkg::OP_JUMP_EQ: begin
                  rf_raddr = reg_r;
                  state_in = (opcode == vce_pkg::OP_STORE) ? ST_SINGLE : ST_OPERAND_A;
               end
               vce_pkg::OP_MOVE: begin
                  rf_raddr = mem_rdata_ff[7:4];
                  state_in = ST_SINGLE;
               end
               vce_pkg::OP_ADD_INT, vce_pkg::OP_ADD_FLOAT: begin
                  rf_raddr = mem_rdata_ff[7:4];
                  state_in = ST_OPERAND_A;
               end
               vce_pkg::OP_HALT: begin
                  halt_in = 1'b1;
                  pc_in   = pc_plus2;
                  done    = 1'b1;
                  done_op = opcode;
               end
               default: begin
                  pc_in    = pc_plus2;
                  done     = 1'b1;
                  done_bad = 1'b1;
               end
            endcase
         end
         ST_MEM_LOAD: begin
            rf_we    = 1'b1;
            rf_wdata = mem_rdata_ff;
            pc_in    = pc_plus2;
            done     = 1'b1;
            done_op  = opcode;
         end
         ST_SINGLE: begin
            if (opcode == vce_pkg::OP_STORE) begin
               mem_we    = 1'b1;
               mem_addr  = ir_lo_ff;
               mem_wdata = rf_rdata_ff;
               if (ir_lo_ff == vce_pkg::DISPLAY_ADDR) begin
                  done_disp_v = 1'b1;
                  done_disp   = rf_rdata_ff;
               end
            end else begin
               rf_we    = 1'b1;
               rf_waddr = ir_lo_ff[RW-1:0];
               rf_wdata = rf_rdata_ff;
            end
            pc_in   = pc_plus2;
            done    = 1'b1;
            done_op = opcode;
         end
         ST_OPERAND_A: begin
            opa_in   = rf_rdata_ff;
            rf_raddr = (opcode == vce_pkg::OP_JUMP_EQ) ? vce_pkg::REG_ZERO
                                                        : ir_lo_ff[RW-1:0];
            state_in = ST_OPERAND_B;
         end
         ST_OPERAND_B: begin
            pc_in   = pc_plus2;
            done    = 1'b1;
            done_op = opcode;
            if (opcode == vce_pkg::OP_JUMP_EQ) begin
               if (opa_ff == rf_rdata_ff) begin
                  pc_in = ir_lo_ff;
               end
            end else begin
               rf_we    = 1'b1;
               rf_wdata = (opcode == vce_pkg::OP_ADD_FLOAT) ? fadd_sum
                                                            : opa_ff + rf_rdata_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_pc_in     = rsp_pc_ff;
      rsp_halt_in   = rsp_halt_ff;
      rsp_disp_v_in = rsp_disp_v_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_op_in     = rsp_op_ff;
      if (done) begin
         state_in      = ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_pc_in     = pc_in;
         rsp_halt_in   = halt_in;
         rsp_disp_v_in = done_disp_v;
         rsp_disp_in   = done_disp;
         rsp_bad_in    = done_bad;
         rsp_op_in     = done_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ir_hi_ff      <= ir_hi_in;
      ir_lo_ff      <= ir_lo_in;
      opa_ff        <= opa_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_halt_ff   <= rsp_halt_in;
      rsp_disp_v_ff <= rsp_disp_v_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_op_ff     <= rsp_op_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem_array[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_array[rf_waddr] <= rf_wdata;
      end
      rf_rdata_ff <= rf_array[rf_raddr];
   end

   assign req_bus.ready           = req_ready;
   assign csr_bus.ready           = 1'b1;
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.program_counter = rsp_pc_ff;
   assign rsp_bus.halted          = rsp_halt_ff;
   assign rsp_bus.display_valid   = rsp_disp_v_ff;
   assign rsp_bus.display_value   = rsp_disp_ff;
   assign rsp_bus.bad_opcode      = rsp_bad_ff;
   assign rsp_bus.executed_opcode = rsp_op_ff;

endmodule

/* design/vce_checker.sv */
// ----------------------------------------------------------------------------
// Vole execute core checker
// Port-level properties of the core's responses, bound into the core.
// ----------------------------------------------------------------------------
`include "vole_cpu_execute_core_macros.svh"

module vce_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_halted,
   input logic                       rsp_display_valid,
   input logic                       rsp_bad_opcode,
   input logic [3:0]                 rsp_executed_opcode
);

   `VCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "Response dropped while stalled.")
   `VCE_ASSERT_IMPL(a_display_store, clock, reset, rsp_valid && rsp_display_valid, rsp_executed_opcode == vce_pkg::OP_STORE, "Display without a store.")
   `VCE_ASSERT_IMPL(a_bad_no_op, clock, reset, rsp_valid && rsp_bad_opcode, rsp_executed_opcode == vce_pkg::OP_NONE && !rsp_display_valid, "Bad opcode reported an execution.")
   `VCE_ASSERT_IMPL(a_halt_flag, clock, reset, rsp_valid && rsp_executed_opcode == vce_pkg::OP_HALT, rsp_halted, "Halt executed without the halt flag.")

endmodule

bind vole_cpu_execute_core vce_checker u_vce_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_halted          (rsp_bus.halted),
   .rsp_display_valid   (rsp_bus.display_valid),
   .rsp_bad_opcode      (rsp_bus.bad_opcode),
   .rsp_executed_opcode (rsp_bus.executed_opcode)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Vole execute core testbench
// Loads short programs into the core's memory, restarts it at several start
// addresses and single-steps them. Each response is checked field by field
// against an instruction-level model of the machine.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 350;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [vce_pkg::ADDR_W-1:0] address;
      logic [vce_pkg::DATA_W-1:0] data;
   } vole_request_type;

   typedef struct packed {
      logic [vce_pkg::ADDR_W-1:0] pc;
      logic                       halted;
      logic                       disp_valid;
      logic [vce_pkg::DATA_W-1:0] disp_value;
      logic                       bad_op;
      logic [3:0]                 opcode;
   } vole_status_type;

   logic clock;
   logic reset;

   vce_req_if req_bus();
   vce_rsp_if rsp_bus();
   vce_csr_if csr_bus();

   vole_cpu_execute_core uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   logic [vce_pkg::DATA_W-1:0] mem_image [vce_pkg::MEMORY_BYTES];
   logic [vce_pkg::DATA_W-1:0] reg_image [vce_pkg::REGISTER_COUNT];
   logic [vce_pkg::ADDR_W-1:0] pc_shadow;
   logic                       halt_shadow;
   logic [vce_pkg::ADDR_W-1:0] start_shadow;

   vole_request_type request_backlog [$];
   vole_status_type  awaited_status [$];
   int requests_queued;
   int requests_taken;
   int mismatch_count;
   int quiet_cycles;
   int send_gap;
   int stall_left;
   bit steady;

   always #10 clock = ~clock;

   task automatic log_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
   endtask

   function automatic int float_units(input logic [vce_pkg::DATA_W-1:0] b);
      int mag;
      mag = int'(b[3:0]);
      mag = mag << b[6:4];
      return b[7] ? -mag : mag;
   endfunction

   function automatic logic [vce_pkg::DATA_W-1:0] float_pack(input int v);
      int unsigned mag;
      int unsigned shifted;
      logic [vce_pkg::DATA_W-1:0] res;
      mag = (v < 0) ? -v : v;
      res = {v < 0, 7'h7F};
      if (mag == 0)
         return '0;
      for (int e = 7; e >= 0; e--) begin
         shifted = mag >> e;
         if (shifted <= 15) begin
            res[6:4] = e[2:0];
            res[3:0] = shifted[3:0];
         end
      end
      return res;
   endfunction

   function automatic vole_status_type vole_predict(
         input logic [1:0] kind,
         input logic [vce_pkg::ADDR_W-1:0] address,
         input logic [vce_pkg::DATA_W-1:0] data);
      vole_status_type st;
      logic [vce_pkg::DATA_W-1:0] hi, lo;
      logic [vce_pkg::ADDR_W-1:0] lo_addr, next;
      logic [3:0] op, r, x, y;
      st = '0;
      case (kind)
         vce_pkg::REQ_WRITE: mem_image[address] = data;
         vce_pkg::REQ_RESTART: begin
            pc_shadow = start_shadow;
            halt_shadow = 1'b0;
         end
         vce_pkg::REQ_EXECUTE: begin
            if (!halt_shadow) begin
               lo_addr = pc_shadow + 8'd1;
               hi = mem_image[pc_shadow];
               lo = mem_image[lo_addr];
               op = hi[7:4];
               r = hi[3:0];
               x = lo[7:4];
               y = lo[3:0];
               next = pc_shadow + 8'd2;
               st.opcode = op;
               case (op)
                  vce_pkg::OP_LOAD_MEM: reg_image[r] = mem_image[lo];
                  vce_pkg::OP_LOAD_IMM: reg_image[r] = lo;
                  vce_pkg::OP_STORE: begin
                     mem_image[lo] = reg_image[r];
                     if (lo == vce_pkg::DISPLAY_ADDR) begin
                        st.disp_valid = 1'b1;
                        st.disp_value = reg_image[r];
                     end
                  end
                  vce_pkg::OP_MOVE: reg_image[y] = reg_image[x];
                  vce_pkg::OP_ADD_INT: reg_image[r] = reg_image[x] + reg_image[y];
                  vce_pkg::OP_ADD_FLOAT:
                     reg_image[r] = float_pack(float_units(reg_image[x]) +
                                               float_units(reg_image[y]));
                  vce_pkg::OP_JUMP_EQ: begin
                     if (reg_image[r] == reg_image[vce_pkg::REG_ZERO])
                        next = lo;
                  end
                  vce_pkg::OP_HALT: halt_shadow = 1'b1;
                  default: begin
                     st.bad_op = 1'b1;
                     st.opcode = vce_pkg::OP_NONE;
                  end
               endcase
               pc_shadow = next;
            end
         end
         default: ;
      endcase
      st.pc = pc_shadow;
      st.halted = halt_shadow;
      return st;
   endfunction

   function automatic logic [15:0] random_instruction();
      logic [3:0] op, r;
      logic [7:0] lo;
      r = 4'($urandom_range(0, 15));
      lo = 8'($urandom_range(0, 255));
      op = vce_pkg::OP_NONE;
      case ($urandom_range(0, 15))
         0, 1: op = vce_pkg::OP_LOAD_IMM;
         2: op = vce_pkg::OP_LOAD_MEM;
         3: begin
            op = vce_pkg::OP_STORE;
            if ($urandom_range(0, 2) == 0)
               lo = vce_pkg::DISPLAY_ADDR;
         end
         4: op = vce_pkg::OP_MOVE;
         5: op = vce_pkg::OP_ADD_INT;
         6, 7: op = vce_pkg::OP_ADD_FLOAT;
         8, 9: begin
            op = vce_pkg::OP_JUMP_EQ;
            if ($urandom_range(0, 1) == 0)
               r = vce_pkg::REG_ZERO;
         end
         10: op = vce_pkg::OP_HALT;
         11: begin
            do
               op = 4'($urandom_range(0, 15));
            while (op inside {vce_pkg::OP_LOAD_MEM, vce_pkg::OP_LOAD_IMM,
                              vce_pkg::OP_STORE, vce_pkg::OP_MOVE,
                              vce_pkg::OP_ADD_INT, vce_pkg::OP_ADD_FLOAT,
                              vce_pkg::OP_JUMP_EQ, vce_pkg::OP_HALT});
         end
         default: op = 4'($urandom_range(0, 15));
      endcase
      return {op, r, lo};
   endfunction

   task automatic queue_request(input logic [1:0] kind,
                                input logic [vce_pkg::ADDR_W-1:0] address,
                                input logic [vce_pkg::DATA_W-1:0] data);
      vole_request_type item;
      item.kind = kind;
      item.address = address;
      item.data = data;
      request_backlog = {request_backlog, item};
      requests_queued++;
   endtask

   task automatic queue_instruction(input logic [vce_pkg::ADDR_W-1:0] at,
                                    input logic [15:0] word);
      logic [vce_pkg::ADDR_W-1:0] at_lo;
      at_lo = at + 8'd1;
      queue_request(vce_pkg::REQ_WRITE, at, word[15:8]);
      queue_request(vce_pkg::REQ_WRITE, at_lo, word[7:0]);
   endtask

   task automatic wait_idle();
      while (requests_taken != requests_queued || awaited_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_start_address(input logic [vce_pkg::ADDR_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do
         @(posedge clock);
      while (csr_bus.ready !== 1'b1);
      start_shadow = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int budget);
      int phase_start, len, steps, pick;
      logic [vce_pkg::ADDR_W-1:0] at;
      phase_start = requests_queued;
      while (requests_queued - phase_start < budget) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            len = $urandom_range(2, 10);
            at = start_shadow;
            for (int i = 0; i < len; i++) begin
               queue_instruction(at, random_instruction());
               at = at + 8'd2;
            end
            repeat ($urandom_range(0, 2))
               queue_request(vce_pkg::REQ_WRITE, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            queue_request(vce_pkg::REQ_RESTART, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            steps = $urandom_range(1, len + 3);
            repeat (steps)
               queue_request(vce_pkg::REQ_EXECUTE, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
         end else if (pick == 7) begin
            queue_request(vce_pkg::REQ_WRITE, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
         end else if (pick == 8) begin
            queue_request($urandom_range(0, 1) ? vce_pkg::REQ_EXECUTE : vce_pkg::REQ_RESTART,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            queue_request(REQ_UNUSED, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
         end
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      vole_request_type item;
      vole_status_type  predicted;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = vole_predict(req_bus.req_type, req_bus.address, req_bus.data);
            awaited_status = {awaited_status, predicted};
            requests_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (request_backlog.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(0, 16);
               req_bus.valid <= 1'b0;
            end else begin
               item = request_backlog.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.req_type <= item.kind;
               req_bus.address <= item.address;
               req_bus.data <= item.data;
            end
         end
      end
   end

   always @(posedge clock) begin
      vole_status_type seen, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.pc = rsp_bus.program_counter;
            seen.halted = rsp_bus.halted;
            seen.disp_valid = rsp_bus.display_valid;
            seen.disp_value = rsp_bus.display_value;
            seen.bad_op = rsp_bus.bad_opcode;
            seen.opcode = rsp_bus.executed_opcode;
            if (awaited_status.size() == 0) begin
               log_mismatch("response without a request", seen.pc, 0);
            end else begin
               want = awaited_status.pop_front();
               if (seen.pc !== want.pc)
                  log_mismatch("program_counter", seen.pc, want.pc);
               if (seen.halted !== want.halted)
                  log_mismatch("halted", seen.halted, want.halted);
               if (seen.disp_valid !== want.disp_valid)
                  log_mismatch("display_valid", seen.disp_valid, want.disp_valid);
               if (seen.disp_value !== want.disp_value)
                  log_mismatch("display_value", seen.disp_value, want.disp_value);
               if (seen.bad_op !== want.bad_op)
                  log_mismatch("bad_opcode", seen.bad_op, want.bad_op);
               if (seen.opcode !== want.opcode)
                  log_mismatch("executed_opcode", seen.opcode, want.opcode);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = vce_pkg::REQ_WRITE;
      req_bus.address = '0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      requests_queued = 0;
      requests_taken = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      steady = 1'b0;
      pc_shadow = '0;
      halt_shadow = 1'b0;
      start_shadow = '0;
      foreach (mem_image[i])
         mem_image[i] = '0;
      foreach (reg_image[i])
         reg_image[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // A short program that touches every opcode, saturates the float add,
      // overflows the signed range of the integer add, shows a byte on the display,
      // jumps into cleared memory and then halts.
      set_start_address(8'h00);
      queue_instruction(8'h00, {vce_pkg::OP_LOAD_IMM, 4'hA, 8'h7F});
      queue_instruction(8'h02, {vce_pkg::OP_ADD_FLOAT, 4'hB, 8'hAA});
      queue_instruction(8'h04, {vce_pkg::OP_ADD_INT, 4'hC, 8'hAB});
      queue_instruction(8'h06, {vce_pkg::OP_LOAD_MEM, 4'hD, 8'h04});
      queue_instruction(8'h08, {vce_pkg::OP_MOVE, 4'h0, 8'hDE});
      queue_instruction(8'h0A, {vce_pkg::OP_STORE, 4'hC, vce_pkg::DISPLAY_ADDR});
      queue_instruction(8'h0C, {vce_pkg::OP_JUMP_EQ, vce_pkg::REG_ZERO, 8'h10});
      queue_request(vce_pkg::REQ_WRITE, 8'h12, {vce_pkg::OP_HALT, 4'h0});
      repeat (10) queue_request(vce_pkg::REQ_EXECUTE, 8'hFF, 8'hFF);
      queue_request(REQ_UNUSED, 8'hFF, 8'h00);
      queue_request(vce_pkg::REQ_RESTART, 8'h00, 8'hFF);
      wait_idle();

      set_start_address(8'hFF);
      run_random_phase(PHASE_ITEMS);
      set_start_address(8'($urandom_range(0, 255)));
      run_random_phase(PHASE_ITEMS);
      set_start_address(8'hFE);
      run_random_phase(PHASE_ITEMS);
      set_start_address(8'($urandom_range(0, 255)));
      run_random_phase(PHASE_ITEMS);
      steady = 1'b1;
      set_start_address(8'h00);
      run_random_phase(PHASE_ITEMS);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/vce_pkg.sv
design/vce_channels.sv
design/vce_fadd.sv
design/vole_cpu_execute_core.sv
design/vce_checker.sv
tb/tb_top.sv
